// ===== rtl/tdf_pkg.sv =====
// Shared constants and controller/datapath interface types for the trial division factoriser.
package tdf_pkg;

	localparam int VALUE_WIDTH   = 16;
	localparam int FACTOR_WIDTH  = 16;
	localparam int MAX_FACTORS   = 15;
	localparam int CNT_WIDTH     = 4;
	localparam int STEP_WIDTH    = $clog2(VALUE_WIDTH);
	localparam int FIRST_DIVISOR = 2;

	// Source of the result item loaded into the output register
	localparam logic [1:0] EMIT_LOOP  = 2'd0;
	localparam logic [1:0] EMIT_FINAL = 2'd1;
	localparam logic [1:0] EMIT_BAD   = 2'd2;

	typedef struct packed {
		logic       load;
		logic       start_div;
		logic       step_div;
		logic       take_factor;
		logic       inc_div;
		logic       emit;
		logic [1:0] emit_sel;
	} cmd_t;

	typedef struct packed {
		logic small_in;
		logic sq_gt;
		logic cnt_max;
		logic div_last;
		logic rem_zero;
		logic rem_one;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/tdf_ctrl.sv =====
// Controller state machine sequencing the trial divisions and result items.
module tdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tdf_pkg::status_t sts,
	output tdf_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CMP    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_DCHK   = 3'd3;
	localparam logic [2:0] ST_EMIT_F = 3'd4;
	localparam logic [2:0] ST_EMIT_L = 3'd5;
	localparam logic [2:0] ST_EMIT_B = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.emit_sel = tdf_pkg::EMIT_LOOP;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.small_in ? ST_EMIT_B : ST_CMP;
				end
			end
			ST_CMP: begin
				// stop once divisor squared passes the cofactor, or the item is full
				if (sts.sq_gt || sts.cnt_max) begin
					state_d = ST_EMIT_L;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step_div = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DCHK;
				end
			end
			ST_DCHK: begin
				if (sts.rem_zero) begin
					cmd.take_factor = 1'b1;
					state_d         = ST_EMIT_F;
				end else begin
					cmd.inc_div = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_EMIT_F: begin
				cmd.emit_sel = tdf_pkg::EMIT_LOOP;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.rem_one ? ST_IDLE : ST_CMP;
				end
			end
			ST_EMIT_L: begin
				cmd.emit_sel = tdf_pkg::EMIT_FINAL;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EMIT_B: begin
				cmd.emit_sel = tdf_pkg::EMIT_BAD;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/tdf_datapath.sv =====
// Datapath: cofactor, divisor and its square, serial restoring divider, output register.
module tdf_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tdf_pkg::VALUE_WIDTH-1:0]    value,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [tdf_pkg::FACTOR_WIDTH-1:0]   factor,
	output logic                               last,
	output logic                               prime_flag,
	output logic                               bad_input,
	input  tdf_pkg::cmd_t                      cmd,
	output tdf_pkg::status_t                   sts
);

	localparam int W = tdf_pkg::VALUE_WIDTH;

	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    dvs_q;
	logic [2*W-1:0]                  sq_q;
	logic [tdf_pkg::CNT_WIDTH-1:0]   cnt_q;
	logic [W:0]                      acc_q;
	logic [W-1:0]                    quo_q;
	logic [tdf_pkg::STEP_WIDTH-1:0]  step_q;
	logic [tdf_pkg::FACTOR_WIDTH-1:0] factor_q;
	logic                            last_q;
	logic                            prime_q;
	logic                            bad_q;
	logic                            out_valid_q;

	logic [W:0]                      shifted;
	logic                            fits;
	logic [tdf_pkg::FACTOR_WIDTH-1:0] emit_factor;
	logic                            emit_last;
	logic                            emit_prime;
	logic                            emit_bad;

	assign shifted = {acc_q[W-1:0], quo_q[W-1]};
	assign fits    = (shifted >= {1'b0, dvs_q});

	assign sts.small_in = (value < W'(tdf_pkg::FIRST_DIVISOR));
	assign sts.sq_gt    = (sq_q > {{W{1'b0}}, rem_q});
	assign sts.cnt_max  = (cnt_q == tdf_pkg::CNT_WIDTH'(tdf_pkg::MAX_FACTORS - 1));
	assign sts.div_last = (step_q == tdf_pkg::STEP_WIDTH'(W - 1));
	assign sts.rem_zero = (acc_q == '0);
	assign sts.rem_one  = (rem_q == W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		emit_factor = '0;
		emit_last   = 1'b1;
		emit_prime  = 1'b0;
		emit_bad    = 1'b0;
		case (cmd.emit_sel)
			tdf_pkg::EMIT_LOOP: begin
				// the cofactor has already been divided: it is the last item when it hit one
				emit_factor = tdf_pkg::FACTOR_WIDTH'(dvs_q);
				emit_last   = (rem_q == W'(1));
			end
			tdf_pkg::EMIT_FINAL: begin
				emit_factor = tdf_pkg::FACTOR_WIDTH'(rem_q);
				emit_prime  = (cnt_q == '0);
			end
			tdf_pkg::EMIT_BAD: begin
				emit_bad = 1'b1;
			end
			default: begin
				emit_bad = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= value;
			dvs_q <= W'(tdf_pkg::FIRST_DIVISOR);
			sq_q  <= (2*W)'(tdf_pkg::FIRST_DIVISOR * tdf_pkg::FIRST_DIVISOR);
		end else if (cmd.take_factor) begin
			rem_q <= quo_q;
		end else if (cmd.inc_div) begin
			// (d+1)^2 = d^2 + 2d + 1
			dvs_q <= dvs_q + W'(1);
			sq_q  <= sq_q + {{(W-1){1'b0}}, dvs_q, 1'b1};
		end

		if (cmd.start_div) begin
			acc_q  <= '0;
			quo_q  <= rem_q;
			step_q <= '0;
		end else if (cmd.step_div) begin
			acc_q  <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q  <= {quo_q[W-2:0], fits};
			step_q <= step_q + tdf_pkg::STEP_WIDTH'(1);
		end

		if (cmd.emit) begin
			factor_q <= emit_factor;
			last_q   <= emit_last;
			prime_q  <= emit_prime;
			bad_q    <= emit_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.take_factor) begin
				cnt_q <= cnt_q + tdf_pkg::CNT_WIDTH'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign factor     = factor_q;
	assign last       = last_q;
	assign prime_flag = prime_q;
	assign bad_input  = bad_q;

endmodule

// ===== rtl/trial_division_factorizer_core.sv =====
// Each trial divisor takes a compare, a 16-bit serial divide and a remainder check, and each
// result item waits for the output register to be free; 16-bit primes near 65535 need
// about 255 divisors, and inputs below 2 go straight to a single bad-input item.
// Throughput: one item at a time, limited by the one-bit-per-cycle restoring divider.
// A result item waits in the output register while the next item is taken in.
// Reset (arst_n, asynchronous, active low) clears the state machine, count and out_valid.
module trial_division_factorizer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tdf_pkg::VALUE_WIDTH-1:0]  value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tdf_pkg::FACTOR_WIDTH-1:0] factor,
	output logic                             last,
	output logic                             prime_flag,
	output logic                             bad_input
);

	tdf_pkg::cmd_t    cmd;
	tdf_pkg::status_t sts;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdf_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.factor     (factor),
		.last       (last),
		.prime_flag (prime_flag),
		.bad_input  (bad_input),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// ===== sim/tb.sv =====
// Testbench for the trial division factoriser core: directed and random values, checked per factor.
`timescale 1ns / 1ps

module tb;

	localparam int VALUE_WIDTH   = tdf_pkg::VALUE_WIDTH;
	localparam int FACTOR_WIDTH  = tdf_pkg::FACTOR_WIDTH;
	localparam int MAX_FACTORS   = tdf_pkg::MAX_FACTORS;
	localparam int FIRST_DIVISOR = tdf_pkg::FIRST_DIVISOR;

	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 100;
	localparam int RANDOM_ITEMS = 120;
	localparam int CALM_ITEMS  = 30;

	typedef struct packed {
		logic [FACTOR_WIDTH-1:0] factor;
		logic                    last;
		logic                    prime_flag;
		logic                    bad_input;
	} factor_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [VALUE_WIDTH-1:0]  value;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [FACTOR_WIDTH-1:0] factor;
	logic                    last;
	logic                    prime_flag;
	logic                    bad_input;

	factor_result_t expected_results[$];
	factor_result_t want;

	bit calm_phase = 1'b0;
	int mismatches = 0;
	int values_sent = 0;
	int results_checked = 0;
	int bad_values = 0;
	int prime_values = 0;
	int most_factors = 0;
	int ready_hold = 0;
	int quiet_cycles = 0;

	trial_division_factorizer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.factor     (factor),
		.last       (last),
		.prime_flag (prime_flag),
		.bad_input  (bad_input)
	);

	always #4 clk = ~clk;

	// Work out the factor results one value must produce and queue them
	function automatic void predict_factors(input logic [VALUE_WIDTH-1:0] v);
		logic [31:0] cofactor;
		logic [31:0] divisor;
		logic [31:0] found[MAX_FACTORS];
		int n;
		bit whole_prime;
		factor_result_t r;
		cofactor = 32'(v);
		divisor = 32'(FIRST_DIVISOR);
		n = 0;
		if (cofactor < 32'(FIRST_DIVISOR)) begin
			r.factor = '0;
			r.last = 1'b1;
			r.prime_flag = 1'b0;
			r.bad_input = 1'b1;
			expected_results.push_back(r);
			bad_values++;
			return;
		end
		while (divisor * divisor <= cofactor) begin
			// leave room for the remaining cofactor as the final factor
			if (n == MAX_FACTORS - 1)
				break;
			if (cofactor % divisor == 0) begin
				found[n] = divisor;
				n++;
				cofactor = cofactor / divisor;
			end else begin
				divisor++;
			end
		end
		if (cofactor > 1) begin
			found[n] = cofactor;
			n++;
		end
		whole_prime = (n == 1) && (found[0] == 32'(v));
		if (whole_prime)
			prime_values++;
		if (n > most_factors)
			most_factors = n;
		for (int k = 0; k < n; k++) begin
			r.factor = found[k][FACTOR_WIDTH-1:0];
			r.last = (k == n - 1);
			r.prime_flag = whole_prime;
			r.bad_input = 1'b0;
			expected_results.push_back(r);
		end
	endfunction

	function automatic void report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endfunction

	// Call at a rising edge; returns at the edge where the item is taken
	task automatic offer_value(input logic [VALUE_WIDTH-1:0] v);
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		predict_factors(v);
		values_sent++;
	endtask

	// Product of small primes, so that the value carries many factors
	function automatic logic [VALUE_WIDTH-1:0] smooth_value();
		int primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
		int acc;
		int p;
		acc = 1;
		for (int k = 0; k < 16; k++) begin
			p = primes[$urandom_range(0, 11) % ($urandom_range(0, 1) ? 12 : 3)];
			if (acc * p > 65535 || $urandom_range(0, 7) == 0)
				break;
			acc = acc * p;
		end
		return VALUE_WIDTH'(acc);
	endfunction

	task automatic test_bad_inputs();
		offer_value(16'd0);
		offer_value(16'd1);
		offer_value(16'd2);
		offer_value(16'd0);
	endtask

	task automatic test_primes();
		offer_value(16'd3);
		offer_value(16'd257);
		offer_value(16'd65521);
		offer_value(16'd32749);
	endtask

	task automatic test_composites();
		offer_value(16'd4);
		offer_value(16'd6);
		offer_value(16'd25);
		offer_value(16'd961);
		offer_value(16'd65025);
		offer_value(16'd65535);
		offer_value(16'd65534);
		offer_value(16'd65532);
		offer_value(16'd4757);
	endtask

	task automatic test_factor_cap();
		// up to fifteen factors: where the cap is hit, the last one is the cofactor left there
		offer_value(16'd32768);
		offer_value(16'd49152);
		offer_value(16'd16384);
		offer_value(16'd61440);
	endtask

	task automatic test_random_mix(input int count);
		logic [VALUE_WIDTH-1:0] v;
		for (int i = 0; i < count; i++) begin
			if (i == count - CALM_ITEMS)
				calm_phase = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: v = VALUE_WIDTH'($urandom_range(0, 65535));
				4, 5:       v = VALUE_WIDTH'($urandom_range(0, 1023));
				6, 7, 8:    v = smooth_value();
				default:    v = VALUE_WIDTH'(1 << $urandom_range(0, 15));
			endcase
			offer_value(v);
		end
	endtask

	// Receiver: random stall bursts, none in the calm phase
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(1, 3) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item factor=%0d last=%0b prime=%0b bad=%0b",
					factor, last, prime_flag, bad_input));
			end else begin
				want = expected_results.pop_front();
				if (factor !== want.factor || last !== want.last ||
						prime_flag !== want.prime_flag || bad_input !== want.bad_input)
					report_mismatch($sformatf(
						"exp factor=%0d last=%0b prime=%0b bad=%0b, got %0d %0b %0b %0b",
						want.factor, want.last, want.prime_flag, want.bad_input,
						factor, last, prime_flag, bad_input));
				results_checked++;
			end
		end
	end

	// Watchdog: give up when no item moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bad_inputs();
		test_primes();
		test_composites();
		test_factor_cap();
		test_random_mix(RANDOM_ITEMS);
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Factorised %0d values: %0d below two, %0d prime, up to %0d factors each.",
			values_sent, bad_values, prime_values, most_factors);
		$display("Checked %0d factor items, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
